@@ hw/rtl/lge_pkg.sv @@
// shared types and constants for the life generation engine
package lge_pkg;

    localparam int GRID_ROWS_DEF = 16;
    localparam int GRID_COLS_DEF = 32;

    localparam int FUNC_W   = 2;
    localparam int SEL_W    = 4;
    localparam int CELLS_W  = 32;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE   = 2'd0,
        FUNC_ADVANCE = 2'd1,
        FUNC_READ    = 2'd2
    } func_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic rd_en;       // read a row word
        logic rd_zero;     // read of a row outside the grid returns zero
        logic wr_host;     // write the requested row
        logic wr_life;     // write the next-generation row
        logic cap_idx;     // capture the row index of a read request
        logic clr_win;     // clear the three-row window
        logic shift;       // shift the returned row into the window
        logic shift_zero;  // shift a dead row in below the bottom edge
        logic load_out;    // load the read result into the output register
    } lge_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic out_busy;    // output register holds a result not taken this cycle
    } lge_stat_t;

endpackage

@@ hw/rtl/lge_ram.sv @@
// generic simple dual-port ram with registered read
module lge_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/lge_ctrl.sv @@
// controller: request decode and row sweep sequencer
module lge_ctrl #(
    parameter int GRID_ROWS = lge_pkg::GRID_ROWS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  lge_pkg::func_t               in_func,
    input  logic [lge_pkg::SEL_W-1:0]    in_row_select,
    input  lge_pkg::lge_stat_t           stat,
    output lge_pkg::lge_cmd_t            cmd,
    output logic [$clog2(GRID_ROWS)-1:0] rd_addr,
    output logic [$clog2(GRID_ROWS)-1:0] wr_addr
);

    import lge_pkg::*;

    localparam int ROW_W = $clog2(GRID_ROWS);
    localparam int CNT_W = $clog2(GRID_ROWS + 3);
    localparam int EXT_W = 9;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_ADV  = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] cnt_wr;
    logic [EXT_W-1:0] sel_ext;
    logic             sel_in_range;
    logic             accept;

    assign sel_ext      = EXT_W'(in_row_select);
    assign sel_in_range = sel_ext < EXT_W'(GRID_ROWS);
    assign s_tready     = (state_reg == ST_IDLE);
    assign accept       = s_tvalid && s_tready;
    assign cnt_wr       = cnt_reg - CNT_W'(3);

    assign rd_addr = (state_reg == ST_IDLE) ? sel_ext[ROW_W-1:0] : cnt_reg[ROW_W-1:0];
    assign wr_addr = (state_reg == ST_IDLE) ? sel_ext[ROW_W-1:0] : cnt_wr[ROW_W-1:0];

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (in_func)
                        FUNC_WRITE: begin
                            cmd.wr_host = sel_in_range;
                        end
                        FUNC_READ: begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_zero = !sel_in_range;
                            cmd.cap_idx = 1'b1;
                            state_next  = ST_READ;
                        end
                        FUNC_ADVANCE: begin
                            cmd.clr_win = 1'b1;
                            cnt_next    = '0;
                            state_next  = ST_ADV;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (!stat.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_ADV: begin
                // read row cnt, shift row cnt-1, write next row cnt-3
                cmd.rd_en      = cnt_reg < CNT_W'(GRID_ROWS);
                cmd.shift      = (cnt_reg >= CNT_W'(1)) && (cnt_reg <= CNT_W'(GRID_ROWS + 1));
                cmd.shift_zero = cnt_reg == CNT_W'(GRID_ROWS + 1);
                cmd.wr_life    = cnt_reg >= CNT_W'(3);
                cnt_next       = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(GRID_ROWS + 2)) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ hw/rtl/lge_datapath.sv @@
// datapath: board memory, row valid bits, three-row window, life rule, output register
module lge_datapath #(
    parameter int GRID_ROWS = lge_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = lge_pkg::GRID_COLS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  lge_pkg::lge_cmd_t                cmd,
    input  logic [$clog2(GRID_ROWS)-1:0]     rd_addr,
    input  logic [$clog2(GRID_ROWS)-1:0]     wr_addr,
    input  logic [lge_pkg::SEL_W-1:0]        in_row_select,
    input  logic [lge_pkg::CELLS_W-1:0]      in_row_cells,
    output lge_pkg::lge_stat_t               stat,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lge_pkg::OUT_DATA_W-1:0]   m_tdata
);

    import lge_pkg::*;

    localparam int PAD_W = GRID_COLS + 2;

    logic [GRID_ROWS-1:0] valid_reg;
    logic                 rd_vld_reg;
    logic [GRID_COLS-1:0] ram_rd_data;
    logic [GRID_COLS-1:0] ram_wr_data;
    logic                 ram_wr_en;
    logic [GRID_COLS-1:0] row_in;
    logic [GRID_COLS-1:0] prev_reg, cur_reg, nxt_reg;
    logic [GRID_COLS-1:0] life_row;
    logic [PAD_W-1:0]     pad_prev, pad_cur, pad_nxt;
    logic [3:0]           ncount;
    logic [SEL_W-1:0]     idx_reg;
    logic                 out_vld_reg;
    logic [SEL_W-1:0]     out_idx_reg;
    logic [CELLS_W-1:0]   out_cells_reg;

    assign ram_wr_en   = cmd.wr_host || cmd.wr_life;
    assign ram_wr_data = cmd.wr_life ? life_row : GRID_COLS'(64'(in_row_cells));

    lge_ram #(
        .WIDTH (GRID_COLS),
        .DEPTH (GRID_ROWS)
    ) u_board (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // a row never written since reset reads as all dead
    assign row_in = (rd_vld_reg && !cmd.shift_zero) ? ram_rd_data : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (ram_wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.rd_en) begin
                rd_vld_reg <= !cmd.rd_zero && valid_reg[rd_addr];
            end
        end
    end

    // window of rows above, at and below the row being computed
    always_ff @(posedge aclk) begin
        if (cmd.clr_win) begin
            prev_reg <= '0;
            cur_reg  <= '0;
            nxt_reg  <= '0;
        end else if (cmd.shift) begin
            prev_reg <= cur_reg;
            cur_reg  <= nxt_reg;
            nxt_reg  <= row_in;
        end
    end

    assign pad_prev = {1'b0, prev_reg, 1'b0};
    assign pad_cur  = {1'b0, cur_reg, 1'b0};
    assign pad_nxt  = {1'b0, nxt_reg, 1'b0};

    always_comb begin
        life_row = '0;
        ncount   = '0;
        for (int c = 0; c < GRID_COLS; c++) begin
            ncount = 4'(pad_prev[c]) + 4'(pad_prev[c+1]) + 4'(pad_prev[c+2])
                   + 4'(pad_cur[c])                      + 4'(pad_cur[c+2])
                   + 4'(pad_nxt[c])  + 4'(pad_nxt[c+1])  + 4'(pad_nxt[c+2]);
            if (cur_reg[c]) begin
                life_row[c] = (ncount == 4'd2) || (ncount == 4'd3);
            end else begin
                life_row[c] = (ncount == 4'd3);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_idx) begin
            idx_reg <= in_row_select;
        end
        if (cmd.load_out) begin
            out_idx_reg   <= idx_reg;
            out_cells_reg <= CELLS_W'(64'(row_in));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    assign stat.out_busy = out_vld_reg && !m_tready;
    assign m_tvalid      = out_vld_reg;
    assign m_tdata       = OUT_DATA_W'({out_cells_reg, out_idx_reg});

endmodule

@@ hw/rtl/life_generation_engine.sv @@
// top level of the life generation engine
// Bounded Game of Life board of GRID_ROWS rows by GRID_COLS columns, one row word
// per memory entry; cells beyond the edges count as dead and the grid does not wrap.
// A request writes one row (func 0), advances the board one generation (func 1) or
// reads one row back (func 2); only a read produces a result, and func 3 is dropped.
// A write is done in its accept cycle; a read registers the row out of the memory and
// then waits for the output register to drain before loading it; an advance accepts
// the request, then sweeps the single board memory doing up to one row read and one
// row write per cycle with a three-row window between them, filling the window before
// the first write and draining it after the last read. The board is all dead after
// reset through per-row valid bits, so no clearing pass is needed.
module life_generation_engine #(
    parameter int GRID_ROWS = lge_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = lge_pkg::GRID_COLS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lge_pkg::IN_DATA_W-1:0]  s_tdata,   // func[1:0], row_select[5:2], row_cells[37:6]
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lge_pkg::OUT_DATA_W-1:0] m_tdata    // read_row_index[3:0], read_row_cells[35:4]
);

    import lge_pkg::*;

    localparam int ROW_W = $clog2(GRID_ROWS);

    // request fields
    func_t              in_func;
    logic [SEL_W-1:0]   in_row_select;
    logic [CELLS_W-1:0] in_row_cells;

    lge_cmd_t           cmd;
    lge_stat_t          stat;
    logic [ROW_W-1:0]   rd_addr;
    logic [ROW_W-1:0]   wr_addr;

    assign in_func       = func_t'(s_tdata[1:0]);
    assign in_row_select = s_tdata[5:2];
    assign in_row_cells  = s_tdata[37:6];

    // sequencer: decodes requests and steps the advance sweep
    lge_ctrl #(
        .GRID_ROWS (GRID_ROWS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .in_func       (in_func),
        .in_row_select (in_row_select),
        .stat          (stat),
        .cmd           (cmd),
        .rd_addr       (rd_addr),
        .wr_addr       (wr_addr)
    );

    // board storage, neighbor counting and the output register
    lge_datapath #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .rd_addr       (rd_addr),
        .wr_addr       (wr_addr),
        .in_row_select (in_row_select),
        .in_row_cells  (in_row_cells),
        .stat          (stat),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule
